@@ rtl/pads_pkg.sv @@
// ----------------------------------------------------------------------------
// Periodic advection-diffusion stencil package
// Types, constants and helper functions shared by the stencil block.
// ----------------------------------------------------------------------------
package pads_pkg;

  localparam int MAX_X      = 16;
  localparam int MAX_Y      = 16;
  localparam int MAX_Z      = 8;
  localparam int FRAC_BITS  = 16;
  localparam int GUARD_BITS = 16;
  localparam int DIFF_FRAC  = 16;

  localparam int SC_DEPTH = MAX_X * MAX_Y * MAX_Z;
  localparam int U_DEPTH  = (MAX_X + 1) * MAX_Y * MAX_Z;
  localparam int V_DEPTH  = MAX_X * (MAX_Y + 1) * MAX_Z;
  localparam int W_DEPTH  = MAX_X * MAX_Y * (MAX_Z + 1);
  localparam int SC_AW    = $clog2(SC_DEPTH);
  localparam int FACE_AW  = $clog2(W_DEPTH);
  localparam int ADDR_W   = FACE_AW;

  localparam int WIDE_W = 63;
  localparam int MAG_W  = 62;
  localparam int NUM_W  = 38;
  localparam int DEN_W  = 36;
  localparam int DIV_W  = 54;
  localparam int FIN_W  = MAG_W - GUARD_BITS;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [MAG_W-1:0]         mag_t;

  localparam mag_t  LIM_MAG = mag_t'(1) << 61;
  localparam wide_t SAT_LIM = wide_t'(LIM_MAG);

  localparam logic [2:0] OP_LOAD_SCALAR = 3'd0;
  localparam logic [2:0] OP_LOAD_U      = 3'd1;
  localparam logic [2:0] OP_LOAD_V      = 3'd2;
  localparam logic [2:0] OP_LOAD_W      = 3'd3;
  localparam logic [2:0] OP_COMPUTE     = 3'd4;

  localparam logic [2:0] CFG_SIZE_X    = 3'd0;
  localparam logic [2:0] CFG_SIZE_Y    = 3'd1;
  localparam logic [2:0] CFG_SIZE_Z    = 3'd2;
  localparam logic [2:0] CFG_SPACING_X = 3'd3;
  localparam logic [2:0] CFG_SPACING_Y = 3'd4;
  localparam logic [2:0] CFG_SPACING_Z = 3'd5;
  localparam logic [2:0] CFG_TIME_STEP = 3'd6;

  localparam logic [20:0] DIFF_TABLE [8] = '{
    21'd1179648, 21'd1272330, 21'd1310720, 21'd1272330,
    21'd1179648, 21'd1086966, 21'd1048576, 21'd1086966
  };

  typedef struct packed {
    logic [2:0]         op;
    logic [11:0]        load_index;
    logic signed [31:0] load_value;
    logic [3:0]         cell_x;
    logic [3:0]         cell_y;
    logic [2:0]         cell_z;
  } in_item_t;

  typedef struct packed {
    logic [10:0]        cell_index;
    logic signed [31:0] new_value;
    logic               saturated;
  } out_item_t;

  function automatic wide_t add_sat(wide_t a, wide_t b);
    logic signed [WIDE_W:0] s;
    s = (WIDE_W + 1)'(a) + (WIDE_W + 1)'(b);
    if (s > (WIDE_W + 1)'(SAT_LIM)) begin
      return SAT_LIM;
    end
    if (s < -((WIDE_W + 1)'(SAT_LIM))) begin
      return -SAT_LIM;
    end
    return wide_t'(s);
  endfunction

  function automatic logic [4:0] wrap_coord(logic [4:0] v, logic signed [2:0] k,
                                            logic [4:0] n);
    logic signed [6:0] s;
    logic signed [6:0] ns;
    ns = signed'({2'b00, n});
    s  = signed'({2'b00, v}) + 7'(k);
    if (s < 0) s = s + ns;
    if (s < 0) s = s + ns;
    if (s >= ns) s = s - ns;
    if (s >= ns) s = s - ns;
    return s[4:0];
  endfunction

  function automatic logic [ADDR_W-1:0] lin_addr(logic [4:0] a, logic [4:0] b,
                                                 logic [4:0] c, logic [4:0] nb,
                                                 logic [4:0] na);
    logic [ADDR_W-1:0] t;
    t = ADDR_W'(c) * ADDR_W'(nb) + ADDR_W'(b);
    return t * ADDR_W'(na) + ADDR_W'(a);
  endfunction

  function automatic logic [4:0] eff_size(logic [4:0] v, logic [4:0] mx);
    if (v == 5'd0) return 5'd1;
    if (v > mx) return mx;
    return v;
  endfunction

endpackage

@@ rtl/pads_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pads_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/periodic_advection_diffusion_stencil.sv @@
// ----------------------------------------------------------------------------
// Periodic advection-diffusion stencil
// Grid memories with a read sequencer, a bit-serial divider and a
// chunked saturating multiplier that update one cell per compute beat.
// ----------------------------------------------------------------------------
// Channel  Signals                      Direction  Content
// in       in_valid/in_ready/in_data    input      load or compute beat
// out      out_valid/out_ready/out_data output     updated cell value
// cfg      cfg_valid/cfg_ready/cfg_*    input      register index and data
//
// A load beat writes its grid in the cycle it is accepted.
// A compute beat reads the stencil, then runs the bit-serial divider for the
// six 54-bit quotients, and then forms five products.
// Reset restores the configuration registers, the state and out_valid; grid contents are undefined until loaded.
// The result register holds a beat until out_ready; a stalled result holds
// the sequencer only at its final step.
// ----------------------------------------------------------------------------
module periodic_advection_diffusion_stencil
  import pads_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [11:0] {
    S_IDLE      = 12'b000000000001,
    S_READ      = 12'b000000000010,
    S_DIV_LOAD  = 12'b000000000100,
    S_DIV_RUN   = 12'b000000001000,
    S_DIV_STORE = 12'b000000010000,
    S_LAP       = 12'b000000100000,
    S_MUL_LOAD  = 12'b000001000000,
    S_MUL_RUN   = 12'b000010000000,
    S_ROUND     = 12'b000100000000,
    S_ACCUM     = 12'b001000000000,
    S_FINAL     = 12'b010000000000,
    S_OUT       = 12'b100000000000
  } state_t;

  localparam int C   = 0;
  localparam int XP1 = 1;
  localparam int XP2 = 2;
  localparam int XM1 = 3;
  localparam int XM2 = 4;
  localparam int YP1 = 5;
  localparam int YP2 = 6;
  localparam int YM1 = 7;
  localparam int YM2 = 8;
  localparam int ZP  = 9;
  localparam int ZM  = 10;

  state_t state;

  logic [4:0]  size_x, size_y;
  logic [3:0]  size_z;
  logic [15:0] spacing_x, spacing_y, spacing_z;
  logic [7:0]  time_step;
  logic [4:0]  nx, ny, nz, nx1, ny1;

  logic [4:0]  cx, cy, cz;
  logic [10:0] cidx;
  logic [3:0]  cnt;
  logic signed [31:0] sc [11];
  logic signed [31:0] u0, u1, v0, v1, w0, w1;

  logic [2:0]       dcnt;
  logic [5:0]       bcnt;
  logic [36:0]      div_rem;
  logic [DIV_W-1:0] div_q;
  logic [DEN_W-1:0] div_den;
  logic             div_neg;
  wide_t            dq [6];

  wide_t lap, adv, dma, total, term;

  logic [2:0]  mcnt, kcnt;
  mag_t        mul_a, mul_acc;
  logic [63:0] mul_b;
  logic        mul_sat_f, mul_neg;

  logic [FIN_W-1:0] fin_mag;
  logic             fin_neg;

  logic in_acc;
  logic in_rng;

  logic                 s_we, u_we, v_we, w_we;
  logic [SC_AW-1:0]     s_raddr;
  logic [FACE_AW-1:0]   u_raddr, v_raddr, w_raddr;
  logic [31:0]          s_rdata, u_rdata, v_rdata, w_rdata;

  logic signed [2:0] kx, ky, kz;
  logic [4:0]        rx, ry, rz;

  logic signed [NUM_W-1:0] e_c, e_xp1, e_xp2, e_xm1, e_xm2;
  logic signed [NUM_W-1:0] e_yp1, e_yp2, e_ym1, e_ym2, e_zp, e_zm;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        num_mag;
  logic [15:0]             sx, sy, sz, sp;
  logic [31:0]             sq;
  logic [DEN_W-1:0]        den;
  logic [DIV_W-1:0]        div_num;
  logic [37:0]             div_sh, div_diff;
  logic                    div_ge;

  wide_t       opa, opb, su, sv, sw;
  mag_t        amag, bmag;
  logic [69:0] pp, nacc;
  logic        over;
  mag_t        rmag, tmag, tsum;

  logic               res_sat;
  logic [31:0]        res_mag;
  logic signed [31:0] res_val;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;

  assign nx  = eff_size(size_x, 5'(MAX_X));
  assign ny  = eff_size(size_y, 5'(MAX_Y));
  assign nz  = eff_size({1'b0, size_z}, 5'(MAX_Z));
  assign nx1 = nx + 5'd1;
  assign ny1 = ny + 5'd1;

  assign in_rng = ({1'b0, in_data.cell_x} < nx) && ({1'b0, in_data.cell_y} < ny) &&
                  ({2'b00, in_data.cell_z} < nz);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x    <= 5'd16;
      size_y    <= 5'd16;
      size_z    <= 4'd8;
      spacing_x <= 16'd900;
      spacing_y <= 16'd900;
      spacing_z <= 16'd120;
      time_step <= 8'd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SIZE_X:    size_x    <= cfg_data[4:0];
        CFG_SIZE_Y:    size_y    <= cfg_data[4:0];
        CFG_SIZE_Z:    size_z    <= cfg_data[3:0];
        CFG_SPACING_X: spacing_x <= cfg_data;
        CFG_SPACING_Y: spacing_y <= cfg_data;
        CFG_SPACING_Z: spacing_z <= cfg_data;
        CFG_TIME_STEP: time_step <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign s_we = in_acc && (in_data.op == OP_LOAD_SCALAR) && (in_data.load_index < SC_DEPTH);
  assign u_we = in_acc && (in_data.op == OP_LOAD_U) && (in_data.load_index < U_DEPTH);
  assign v_we = in_acc && (in_data.op == OP_LOAD_V) && (in_data.load_index < V_DEPTH);
  assign w_we = in_acc && (in_data.op == OP_LOAD_W) && (in_data.load_index < W_DEPTH);

  always_comb begin
    kx = 3'sd0;
    ky = 3'sd0;
    kz = 3'sd0;
    unique case (cnt)
      4'd1:    kx = 3'sd1;
      4'd2:    kx = 3'sd2;
      4'd3:    kx = -3'sd1;
      4'd4:    kx = -3'sd2;
      4'd5:    ky = 3'sd1;
      4'd6:    ky = 3'sd2;
      4'd7:    ky = -3'sd1;
      4'd8:    ky = -3'sd2;
      4'd9:    kz = 3'sd1;
      4'd10:   kz = -3'sd1;
      default: ;
    endcase
  end

  assign rx = wrap_coord(cx, kx, nx);
  assign ry = wrap_coord(cy, ky, ny);
  assign rz = wrap_coord(cz, kz, nz);

  always_comb begin
    logic [ADDR_W-1:0] sa;
    sa      = lin_addr(rx, ry, rz, ny, nx);
    s_raddr = sa[SC_AW-1:0];
    if (cnt == 4'd0) begin
      u_raddr = lin_addr(cx, cy, cz, ny, nx1);
      v_raddr = lin_addr(cx, cy, cz, ny1, nx);
      w_raddr = lin_addr(cx, cy, cz, ny, nx);
    end else begin
      u_raddr = lin_addr(cx + 5'd1, cy, cz, ny, nx1);
      v_raddr = lin_addr(cx, cy + 5'd1, cz, ny1, nx);
      w_raddr = lin_addr(cx, cy, cz + 5'd1, ny, nx);
    end
  end

  pads_ram #(.WIDTH(32), .DEPTH(SC_DEPTH)) u_scalar_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (in_data.load_index[SC_AW-1:0]),
    .wdata (in_data.load_value),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  pads_ram #(.WIDTH(32), .DEPTH(U_DEPTH)) u_uface_ram (
    .clk   (clk),
    .we    (u_we),
    .waddr (in_data.load_index[FACE_AW-1:0]),
    .wdata (in_data.load_value),
    .raddr (u_raddr),
    .rdata (u_rdata)
  );

  pads_ram #(.WIDTH(32), .DEPTH(V_DEPTH)) u_vface_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (in_data.load_index[FACE_AW-1:0]),
    .wdata (in_data.load_value),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  pads_ram #(.WIDTH(32), .DEPTH(W_DEPTH)) u_wface_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (in_data.load_index[FACE_AW-1:0]),
    .wdata (in_data.load_value),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  assign e_c   = NUM_W'(sc[C]);
  assign e_xp1 = NUM_W'(sc[XP1]);
  assign e_xp2 = NUM_W'(sc[XP2]);
  assign e_xm1 = NUM_W'(sc[XM1]);
  assign e_xm2 = NUM_W'(sc[XM2]);
  assign e_yp1 = NUM_W'(sc[YP1]);
  assign e_yp2 = NUM_W'(sc[YP2]);
  assign e_ym1 = NUM_W'(sc[YM1]);
  assign e_ym2 = NUM_W'(sc[YM2]);
  assign e_zp  = NUM_W'(sc[ZP]);
  assign e_zm  = NUM_W'(sc[ZM]);

  assign sx = (spacing_x == 16'd0) ? 16'd1 : spacing_x;
  assign sy = (spacing_y == 16'd0) ? 16'd1 : spacing_y;
  assign sz = (spacing_z == 16'd0) ? 16'd1 : spacing_z;

  always_comb begin
    num = '0;
    sp  = sx;
    case (dcnt)
      3'd0: num = -e_xp2 + (e_xp1 <<< 3) - (e_xm1 <<< 3) + e_xm2;
      3'd1: begin
        num = -e_yp2 + (e_yp1 <<< 3) - (e_ym1 <<< 3) + e_ym2;
        sp  = sy;
      end
      3'd2: begin
        num = e_zp - e_zm;
        sp  = sz;
      end
      3'd3: num = -e_xp2 + (e_xp1 <<< 4) - (e_c <<< 5) + (e_c <<< 1) + (e_xm1 <<< 4) - e_xm2;
      3'd4: begin
        num = -e_yp2 + (e_yp1 <<< 4) - (e_c <<< 5) + (e_c <<< 1) + (e_ym1 <<< 4) - e_ym2;
        sp  = sy;
      end
      3'd5: begin
        num = e_zp - (e_c <<< 1) + e_zm;
        sp  = sz;
      end
      default: ;
    endcase
  end

  assign sq = 32'(sp) * 32'(sp);

  always_comb begin
    case (dcnt)
      3'd0, 3'd1: den = (DEN_W'(sp) << 3) + (DEN_W'(sp) << 2);
      3'd2:       den = DEN_W'(sp) << 1;
      3'd3, 3'd4: den = (DEN_W'(sq) << 3) + (DEN_W'(sq) << 2);
      default:    den = DEN_W'(sq);
    endcase
  end

  assign num_mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign div_num  = (DIV_W'(num_mag) << GUARD_BITS) + DIV_W'(den >> 1);
  assign div_sh   = {div_rem, div_q[DIV_W-1]};
  assign div_diff = div_sh - 38'(div_den);
  assign div_ge   = (div_sh >= 38'(div_den));

  assign su = wide_t'(u0) + wide_t'(u1);
  assign sv = wide_t'(v0) + wide_t'(v1);
  assign sw = wide_t'(w0) + wide_t'(w1);

  always_comb begin
    opa = '0;
    opb = '0;
    case (mcnt)
      3'd0: begin
        opa = su;
        opb = dq[0];
      end
      3'd1: begin
        opa = sv;
        opb = dq[1];
      end
      3'd2: begin
        opa = sw;
        opb = dq[2];
      end
      3'd3: begin
        opa = wide_t'(DIFF_TABLE[cz[2:0]]);
        opb = lap;
      end
      3'd4: begin
        opa = wide_t'(time_step);
        opb = dma;
      end
      default: ;
    endcase
  end

  assign amag = opa[WIDE_W-1] ? mag_t'(-opa) : mag_t'(opa);
  assign bmag = opb[WIDE_W-1] ? mag_t'(-opb) : mag_t'(opb);

  assign pp   = mul_a * mul_b[63:56];
  assign nacc = {mul_acc, 8'b0} + pp;
  assign over = mul_sat_f || (nacc > 70'(LIM_MAG));

  always_comb begin
    case (mcnt)
      3'd0, 3'd1, 3'd2: rmag = (mul_acc + (mag_t'(1) << FRAC_BITS)) >> (FRAC_BITS + 1);
      3'd3:             rmag = (mul_acc + (mag_t'(1) << (DIFF_FRAC - 1))) >> DIFF_FRAC;
      default:          rmag = mul_acc;
    endcase
  end

  assign tmag = total[WIDE_W-1] ? mag_t'(-total) : mag_t'(total);
  assign tsum = (tmag + (mag_t'(1) << (GUARD_BITS - 1))) >> GUARD_BITS;

  assign res_sat = fin_neg ? (fin_mag > FIN_W'(33'h080000000))
                           : (fin_mag > FIN_W'(33'h07fffffff));
  assign res_mag = fin_mag[31:0];
  always_comb begin
    if (res_sat) begin
      res_val = fin_neg ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      res_val = fin_neg ? signed'(-res_mag) : signed'(res_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && (in_data.op == OP_COMPUTE) && in_rng) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (cnt == 4'd11) state <= S_DIV_LOAD;
        end
        S_DIV_LOAD: state <= S_DIV_RUN;
        S_DIV_RUN: begin
          if (bcnt == 6'(DIV_W - 1)) state <= S_DIV_STORE;
        end
        S_DIV_STORE: state <= (dcnt == 3'd5) ? S_LAP : S_DIV_LOAD;
        S_LAP:       state <= S_MUL_LOAD;
        S_MUL_LOAD:  state <= S_MUL_RUN;
        S_MUL_RUN: begin
          if (kcnt == 3'd7) state <= S_ROUND;
        end
        S_ROUND:     state <= S_ACCUM;
        S_ACCUM:     state <= (mcnt == 3'd4) ? S_FINAL : S_MUL_LOAD;
        S_FINAL:     state <= S_OUT;
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cx   <= {1'b0, in_data.cell_x};
        cy   <= {1'b0, in_data.cell_y};
        cz   <= {2'b00, in_data.cell_z};
        cidx <= 11'(lin_addr({1'b0, in_data.cell_x}, {1'b0, in_data.cell_y},
                             {2'b00, in_data.cell_z}, ny, nx));
        cnt  <= 4'd0;
      end
      S_READ: begin
        if (cnt != 4'd0) sc[cnt - 4'd1] <= signed'(s_rdata);
        if (cnt == 4'd1) begin
          u0 <= signed'(u_rdata);
          v0 <= signed'(v_rdata);
          w0 <= signed'(w_rdata);
        end
        if (cnt == 4'd2) begin
          u1 <= signed'(u_rdata);
          v1 <= signed'(v_rdata);
          w1 <= signed'(w_rdata);
        end
        cnt  <= cnt + 4'd1;
        dcnt <= 3'd0;
      end
      S_DIV_LOAD: begin
        div_q   <= div_num;
        div_rem <= '0;
        div_den <= den;
        div_neg <= num[NUM_W-1];
        bcnt    <= 6'd0;
      end
      S_DIV_RUN: begin
        div_q   <= {div_q[DIV_W-2:0], div_ge};
        div_rem <= div_ge ? div_diff[36:0] : div_sh[36:0];
        bcnt    <= bcnt + 6'd1;
      end
      S_DIV_STORE: begin
        dq[dcnt] <= div_neg ? -wide_t'(div_q) : wide_t'(div_q);
        dcnt     <= dcnt + 3'd1;
      end
      S_LAP: begin
        lap  <= add_sat(add_sat(dq[3], dq[4]), dq[5]);
        adv  <= '0;
        mcnt <= 3'd0;
      end
      S_MUL_LOAD: begin
        mul_a     <= amag;
        mul_b     <= 64'(bmag);
        mul_acc   <= '0;
        mul_sat_f <= 1'b0;
        mul_neg   <= opa[WIDE_W-1] ^ opb[WIDE_W-1];
        kcnt      <= 3'd0;
      end
      S_MUL_RUN: begin
        mul_acc   <= over ? LIM_MAG : nacc[MAG_W-1:0];
        mul_sat_f <= over;
        mul_b     <= mul_b << 8;
        kcnt      <= kcnt + 3'd1;
      end
      S_ROUND: begin
        term <= mul_neg ? -wide_t'(rmag) : wide_t'(rmag);
      end
      S_ACCUM: begin
        case (mcnt)
          3'd3:    dma   <= add_sat(term, -adv);
          3'd4:    total <= add_sat(wide_t'(sc[C]) <<< GUARD_BITS, term);
          default: adv   <= add_sat(adv, term);
        endcase
        mcnt <= mcnt + 3'd1;
      end
      S_FINAL: begin
        fin_mag <= tsum[FIN_W-1:0];
        fin_neg <= total[WIDE_W-1];
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_data.cell_index <= cidx;
          out_data.new_value  <= res_val;
          out_data.saturated  <= res_sat;
        end
      end
      default: ;
    endcase
  end

endmodule
